/* sv/pcisb_pkg.sv */
// Shared types, codes and the reset table of the bridge configuration space.
// Used by pcisb_ctrl, pcisb_datapath and pci_southbridge_config_space.
package pcisb_pkg;

   localparam int unsigned ADDR_W = 8;
   localparam int unsigned BYTE_W = 8;
   localparam int unsigned FUNC_W = 3;
   localparam int unsigned DEPTH  = 256;
   localparam int unsigned REQ_W  = 24;
   localparam int unsigned RSP_W  = 24;

   typedef enum logic [1:0] {
      OP_CFG_READ  = 2'd0,
      OP_CFG_WRITE = 2'd1,
      OP_RST_READ  = 2'd2,
      OP_RST_WRITE = 2'd3
   } op_type;

   localparam logic [1:0] P92_NONE    = 2'd0;
   localparam logic [1:0] P92_ENABLE  = 2'd1;
   localparam logic [1:0] P92_DISABLE = 2'd2;

   localparam logic [1:0] RST_NONE = 2'd0;
   localparam logic [1:0] RST_CPU  = 2'd1;
   localparam logic [1:0] RST_FULL = 2'd2;

   localparam logic [7:0] REG_VENDOR_LO = 8'h00;
   localparam logic [7:0] REG_DEVICE_HI = 8'h03;
   localparam logic [7:0] REG_COMMAND   = 8'h04;
   localparam logic [7:0] REG_STATUS_0  = 8'h05;
   localparam logic [7:0] REG_STATUS_1  = 8'h06;
   localparam logic [7:0] REG_STATUS_2  = 8'h07;
   localparam logic [7:0] REG_REVISION  = 8'h08;
   localparam logic [7:0] REG_CLASS_HI  = 8'h0b;
   localparam logic [7:0] REG_HDR_TYPE  = 8'h0e;
   localparam logic [7:0] REG_RO_LO     = 8'h0f;
   localparam logic [7:0] REG_RO_HI     = 8'h4b;
   localparam logic [7:0] REG_PORT92    = 8'h4f;
   localparam logic [7:0] REG_ROUTE_A   = 8'h60;
   localparam logic [7:0] REG_ROUTE_D   = 8'h63;

   typedef enum logic [1:0] {
      ST_IDLE   = 2'd0,
      ST_LOOKUP = 2'd1,
      ST_EXEC   = 2'd2
   } state_type;

   typedef struct packed {
      logic capture;   // latch the accepted word
      logic lookup;    // read the byte store
      logic commit;    // update state, load the output register
   } cmd_type;

   typedef struct packed {
      logic out_stall; // output register holds a word nobody takes
   } status_type;

   function automatic logic [7:0] default_byte(input logic [7:0] addr);
      logic [7:0] val;
      unique case (addr)
         8'h00: val = 8'h86;
         8'h01: val = 8'h80;
         8'h02: val = 8'h84;
         8'h03: val = 8'h04;
         8'h04: val = 8'h07;
         8'h07: val = 8'h02;
         8'h08: val = 8'h03;
         8'h40: val = 8'h20;
         8'h42: val = 8'h04;
         8'h44: val = 8'h20;
         8'h45: val = 8'h10;
         8'h46: val = 8'h0f;
         8'h48: val = 8'h01;
         8'h49: val = 8'h10;
         8'h4a: val = 8'h10;
         8'h4b: val = 8'h0f;
         8'h4c: val = 8'h56;
         8'h4d: val = 8'h40;
         8'h4e: val = 8'h07;
         8'h4f: val = 8'h4f;
         8'h60: val = 8'h80;
         8'h61: val = 8'h80;
         8'h62: val = 8'h80;
         8'h63: val = 8'h80;
         8'h80: val = 8'h78;
         8'ha0: val = 8'h08;
         8'ha8: val = 8'h0f;
         default: val = 8'h00;
      endcase
      return val;
   endfunction

endpackage

/* sv/pcisb_ctrl.sv */
// Sequencer for one access: capture, store lookup, execute.
// Depends on pcisb_pkg for the state and command types.
module pcisb_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  pcisb_pkg::status_type status,
   output pcisb_pkg::cmd_type    cmd
);

   pcisb_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pcisb_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         pcisb_pkg::ST_IDLE: begin
            if (req_tvalid) state_in = pcisb_pkg::ST_LOOKUP;
         end
         pcisb_pkg::ST_LOOKUP: begin
            state_in = pcisb_pkg::ST_EXEC;
         end
         pcisb_pkg::ST_EXEC: begin
            if (!status.out_stall) state_in = pcisb_pkg::ST_IDLE;
         end
         default: state_in = pcisb_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready  = 1'b0;
      cmd.capture = 1'b0;
      cmd.lookup  = 1'b0;
      cmd.commit  = 1'b0;
      unique case (state_ff)
         pcisb_pkg::ST_IDLE: begin
            req_tready  = 1'b1;
            cmd.capture = req_tvalid;
         end
         pcisb_pkg::ST_LOOKUP: begin
            cmd.lookup = 1'b1;
         end
         pcisb_pkg::ST_EXEC: begin
            // hold until the output register frees up
            cmd.commit = !status.out_stall;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

endmodule

/* sv/pcisb_datapath.sv */
// Byte store, reset control register, access decode and output register.
// Depends on pcisb_pkg for codes, the reset table and command types.
module pcisb_datapath (
   input  logic                        clock,
   input  logic                        reset,
   input  pcisb_pkg::cmd_type          cmd,
   output pcisb_pkg::status_type       status,
   input  logic [1:0]                  req_op,
   input  logic [pcisb_pkg::FUNC_W-1:0] req_func,
   input  logic [pcisb_pkg::ADDR_W-1:0] req_addr,
   input  logic [pcisb_pkg::BYTE_W-1:0] req_data,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [pcisb_pkg::RSP_W-1:0] rsp_tdata
);

   logic [7:0] cfg_mem_ff [pcisb_pkg::DEPTH];
   logic [pcisb_pkg::DEPTH-1:0] vld_ff, vld_in;

   pcisb_pkg::op_type op_ff;
   logic [2:0] func_ff;
   logic [7:0] addr_ff, data_ff;
   logic [7:0] rd_ff;
   logic       hit_ff;
   logic [7:0] rst_ctl_ff, rst_ctl_in;

   logic        out_vld_ff, out_vld_in;
   logic [19:0] out_ff, out_in;

   logic [7:0] cur;
   logic [7:0] wr_val;
   logic       wr_en;
   logic       full_rst;
   logic [7:0] read_data;
   logic [1:0] p92_evt;
   logic       route_vld;
   logic [1:0] route_pin;
   logic       route_dis;
   logic [3:0] route_irq;
   logic [1:0] rst_req;

   assign status.out_stall = out_vld_ff && !rsp_tready;

   // capture the accepted word
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff   <= pcisb_pkg::op_type'(req_op);
         func_ff <= req_func;
         addr_ff <= req_addr;
         data_ff <= req_data;
      end
   end

   // byte store: registered read, single write port
   always_ff @(posedge clock) begin
      if (cmd.lookup) begin
         rd_ff  <= cfg_mem_ff[addr_ff];
         hit_ff <= vld_ff[addr_ff];
      end
      if (wr_en) begin
         cfg_mem_ff[addr_ff] <= wr_val;
      end
   end

   assign cur = hit_ff ? rd_ff : pcisb_pkg::default_byte(addr_ff);

   always_comb begin
      read_data = 8'h00;
      p92_evt   = pcisb_pkg::P92_NONE;
      route_vld = 1'b0;
      route_pin = 2'd0;
      route_dis = 1'b0;
      route_irq = 4'd0;
      rst_req   = pcisb_pkg::RST_NONE;
      wr_en     = 1'b0;
      wr_val    = data_ff;
      full_rst  = 1'b0;
      rst_ctl_in = rst_ctl_ff;
      case (op_ff)
         pcisb_pkg::OP_CFG_READ: begin
            read_data = (func_ff != 3'd0) ? 8'hff : cur;
         end
         pcisb_pkg::OP_CFG_WRITE: begin
            if (func_ff == 3'd0) begin
               wr_en = 1'b1;
               if (addr_ff >= pcisb_pkg::REG_RO_LO && addr_ff <= pcisb_pkg::REG_RO_HI) begin
                  wr_en = 1'b0;
               end else begin
                  case (addr_ff) inside
                     [pcisb_pkg::REG_VENDOR_LO:pcisb_pkg::REG_DEVICE_HI],
                     [pcisb_pkg::REG_REVISION:pcisb_pkg::REG_CLASS_HI],
                     pcisb_pkg::REG_HDR_TYPE: begin
                        wr_en = 1'b0;
                     end
                     pcisb_pkg::REG_COMMAND: begin
                        wr_val = (data_ff & 8'h08) | 8'h07;
                     end
                     pcisb_pkg::REG_STATUS_0, pcisb_pkg::REG_STATUS_1: begin
                        wr_val = 8'h00;
                     end
                     pcisb_pkg::REG_STATUS_2: begin
                        wr_val = 8'h02;
                     end
                     pcisb_pkg::REG_PORT92: begin
                        // drop the write when bit 6 does not toggle
                        if (((data_ff ^ cur) & 8'h40) == 8'h00) begin
                           wr_en = 1'b0;
                        end else begin
                           p92_evt = data_ff[6] ? pcisb_pkg::P92_ENABLE
                                                : pcisb_pkg::P92_DISABLE;
                        end
                     end
                     [pcisb_pkg::REG_ROUTE_A:pcisb_pkg::REG_ROUTE_D]: begin
                        route_vld = 1'b1;
                        // offsets map to pins A, C, B, D
                        route_pin = {addr_ff[0], addr_ff[1]};
                        route_dis = data_ff[7];
                        route_irq = data_ff[7] ? 4'd0 : data_ff[3:0];
                     end
                     default: begin
                        wr_en = 1'b1;
                     end
                  endcase
               end
            end
         end
         pcisb_pkg::OP_RST_READ: begin
            read_data = rst_ctl_ff & 8'hfb;
         end
         default: begin
            if (!rst_ctl_ff[2] && data_ff[2]) begin
               if (data_ff[1]) begin
                  rst_req  = pcisb_pkg::RST_FULL;
                  full_rst = 1'b1;
               end else begin
                  rst_req = pcisb_pkg::RST_CPU;
               end
            end
            rst_ctl_in = data_ff & 8'hfd;
         end
      endcase
      wr_en = wr_en && cmd.commit;
   end

   always_comb begin
      vld_in = vld_ff;
      if (cmd.commit && full_rst) begin
         vld_in = '0;
      end else if (wr_en) begin
         vld_in[addr_ff] = 1'b1;
      end
   end

   always_comb begin
      out_vld_in = out_vld_ff && !rsp_tready;
      out_in     = out_ff;
      if (cmd.commit) begin
         out_vld_in = 1'b1;
         out_in = {rst_req, route_irq, route_dis, route_pin, route_vld, p92_evt, read_data};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= '0;
         rst_ctl_ff <= 8'h00;
         out_vld_ff <= 1'b0;
      end else begin
         vld_ff     <= vld_in;
         out_vld_ff <= out_vld_in;
         if (cmd.commit) rst_ctl_ff <= rst_ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {4'h0, out_ff};

endmodule

/* sv/pci_southbridge_config_space.sv */
// PCI-to-ISA bridge configuration space with reset control port.
// Each access runs capture, registered byte-store read and read-modify-write;
// rsp_tvalid rises when the last step loads the output register. A new access
// is taken only once the previous one commits, later while rsp_tready is low.
// Reset (synchronous, active high) restores the default table through
// per-byte valid bits at once and clears the reset control register.
module pci_southbridge_config_space (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   // [1:0] operation
   input  logic [1:0]                   req_tuser,
   // [2:0] function_number, [10:3] reg_address, [18:11] write_data, [23:19] zero
   input  logic [pcisb_pkg::REQ_W-1:0]  req_tdata,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   // [7:0] read_data, [9:8] port92_event, [10] route_valid, [12:11] route_pin,
   // [13] route_disabled, [17:14] route_irq, [19:18] reset_request, [23:20] zero
   output logic [pcisb_pkg::RSP_W-1:0]  rsp_tdata
);

   pcisb_pkg::cmd_type    cmd;
   pcisb_pkg::status_type status;

   pcisb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   pcisb_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_op     (req_tuser),
      .req_func   (req_tdata[2:0]),
      .req_addr   (req_tdata[10:3]),
      .req_data   (req_tdata[18:11]),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

/* tb/pcisb_access_checker.sv */
// Checker for the bridge configuration space: watches both streams, predicts each
// response from its own copy of the byte store and reset control register.
// Depends on pcisb_pkg for the operation codes and register offsets.
`timescale 1ns / 1ps

module pcisb_access_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   input  logic                          req_tready,
   input  logic [1:0]                    req_tuser,
   input  logic [pcisb_pkg::REQ_W-1:0]   req_tdata,
   input  logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   input  logic [pcisb_pkg::RSP_W-1:0]   rsp_tdata,
   output int                            fail_count,
   output int                            outstanding,
   output int                            responses_checked
);

   localparam logic [7:0] REG_ROUTE_C   = 8'h61;
   localparam logic [7:0] REG_ROUTE_B   = 8'h62;

   localparam logic [7:0] CMD_KEEP_MASK  = 8'h08;
   localparam logic [7:0] CMD_FORCED     = 8'h07;
   localparam logic [7:0] STATUS_2_FIXED = 8'h02;
   localparam int         P92_BIT        = 6;
   localparam int         ROUTE_OFF_BIT  = 7;
   localparam int         RST_GO_BIT     = 2;
   localparam int         RST_FULL_BIT   = 1;

   localparam logic [1:0] PIN_A = 2'd0;
   localparam logic [1:0] PIN_B = 2'd1;
   localparam logic [1:0] PIN_C = 2'd2;
   localparam logic [1:0] PIN_D = 2'd3;

   typedef struct packed {
      logic [1:0] reset_request;
      logic [3:0] route_irq;
      logic       route_disabled;
      logic [1:0] route_pin;
      logic       route_valid;
      logic [1:0] port92_event;
      logic [7:0] read_data;
   } access_result_type;

   logic [7:0]        cfg_space [256];
   logic [7:0]        rst_ctl;
   access_result_type pending_rsp [$];

   function automatic void load_reset_table();
      for (int i = 0; i < 256; i++) cfg_space[i] = 8'h00;
      cfg_space[8'h00] = 8'h86; cfg_space[8'h01] = 8'h80;
      cfg_space[8'h02] = 8'h84; cfg_space[8'h03] = 8'h04;
      cfg_space[8'h04] = 8'h07; cfg_space[8'h07] = 8'h02;
      cfg_space[8'h08] = 8'h03;
      cfg_space[8'h40] = 8'h20; cfg_space[8'h42] = 8'h04;
      cfg_space[8'h44] = 8'h20; cfg_space[8'h45] = 8'h10;
      cfg_space[8'h46] = 8'h0f; cfg_space[8'h48] = 8'h01;
      cfg_space[8'h49] = 8'h10; cfg_space[8'h4a] = 8'h10;
      cfg_space[8'h4b] = 8'h0f; cfg_space[8'h4c] = 8'h56;
      cfg_space[8'h4d] = 8'h40; cfg_space[8'h4e] = 8'h07;
      cfg_space[8'h4f] = 8'h4f;
      for (int i = pcisb_pkg::REG_ROUTE_A; i <= pcisb_pkg::REG_ROUTE_D; i++) begin
         cfg_space[i] = 8'h80;
      end
      cfg_space[8'h80] = 8'h78; cfg_space[8'ha0] = 8'h08;
      cfg_space[8'ha8] = 8'h0f;
   endfunction

   // Apply one access to the shadow state and return the response it causes.
   function automatic access_result_type predict_access(pcisb_pkg::op_type op,
                                                        logic [2:0] fn,
                                                        logic [7:0] addr,
                                                        logic [7:0] data);
      access_result_type r;
      logic [7:0]        val;
      logic              store;
      r = '0;
      val = data;
      store = 1'b1;
      case (op)
         pcisb_pkg::OP_CFG_READ: begin
            r.read_data = (fn != 3'd0) ? 8'hff : cfg_space[addr];
         end
         pcisb_pkg::OP_CFG_WRITE: begin
            if (fn != 3'd0) begin
               store = 1'b0;
            end else if ((addr >= pcisb_pkg::REG_RO_LO && addr <= pcisb_pkg::REG_RO_HI) ||
                         addr <= pcisb_pkg::REG_DEVICE_HI ||
                         (addr >= pcisb_pkg::REG_REVISION &&
                          addr <= pcisb_pkg::REG_CLASS_HI) ||
                         addr == pcisb_pkg::REG_HDR_TYPE) begin
               store = 1'b0;
            end else if (addr == pcisb_pkg::REG_COMMAND) begin
               val = (data & CMD_KEEP_MASK) | CMD_FORCED;
            end else if (addr == pcisb_pkg::REG_STATUS_0 ||
                         addr == pcisb_pkg::REG_STATUS_1) begin
               val = 8'h00;
            end else if (addr == pcisb_pkg::REG_STATUS_2) begin
               val = STATUS_2_FIXED;
            end else if (addr == pcisb_pkg::REG_PORT92) begin
               // no toggle of the gate bit: drop the write entirely
               if (data[P92_BIT] == cfg_space[pcisb_pkg::REG_PORT92][P92_BIT]) begin
                  store = 1'b0;
               end else begin
                  r.port92_event = data[P92_BIT] ? pcisb_pkg::P92_ENABLE
                                                 : pcisb_pkg::P92_DISABLE;
               end
            end else if (addr >= pcisb_pkg::REG_ROUTE_A && addr <= pcisb_pkg::REG_ROUTE_D) begin
               r.route_valid = 1'b1;
               case (addr)
                  pcisb_pkg::REG_ROUTE_A: r.route_pin = PIN_A;
                  REG_ROUTE_C:            r.route_pin = PIN_C;
                  REG_ROUTE_B:            r.route_pin = PIN_B;
                  default:                r.route_pin = PIN_D;
               endcase
               if (data[ROUTE_OFF_BIT]) r.route_disabled = 1'b1;
               else r.route_irq = data[3:0];
            end
            if (store) cfg_space[addr] = val;
         end
         pcisb_pkg::OP_RST_READ: begin
            r.read_data = rst_ctl;
            r.read_data[RST_GO_BIT] = 1'b0;
         end
         default: begin
            if (!rst_ctl[RST_GO_BIT] && data[RST_GO_BIT]) begin
               if (data[RST_FULL_BIT]) begin
                  r.reset_request = pcisb_pkg::RST_FULL;
                  load_reset_table();
               end else begin
                  r.reset_request = pcisb_pkg::RST_CPU;
               end
            end
            rst_ctl = data;
            rst_ctl[RST_FULL_BIT] = 1'b0;
         end
      endcase
      return r;
   endfunction

   function automatic int field_mismatch(string name, logic [7:0] want, logic [7:0] got);
      if (want === got) return 0;
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      return 1;
   endfunction

   initial begin
      fail_count = 0;
      outstanding = 0;
      responses_checked = 0;
   end

   always @(posedge clock) begin : watch
      access_result_type want;
      access_result_type got;
      int                errs;
      if (reset) begin
         load_reset_table();
         rst_ctl = 8'h00;
         pending_rsp.delete();
      end else begin
         // retire the response first: it always belongs to an older word
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[$bits(access_result_type)-1:0];
            if (pending_rsp.size() == 0) begin
               $error("response 0x%0h arrived with no access outstanding", rsp_tdata);
               fail_count <= fail_count + 1;
            end else begin
               want = pending_rsp.pop_front();
               errs = 0;
               errs += field_mismatch("read_data", want.read_data, got.read_data);
               errs += field_mismatch("port92_event", want.port92_event, got.port92_event);
               errs += field_mismatch("route_valid", want.route_valid, got.route_valid);
               errs += field_mismatch("route_pin", want.route_pin, got.route_pin);
               errs += field_mismatch("route_disabled", want.route_disabled,
                                      got.route_disabled);
               errs += field_mismatch("route_irq", want.route_irq, got.route_irq);
               errs += field_mismatch("reset_request", want.reset_request,
                                      got.reset_request);
               fail_count <= fail_count + errs;
               responses_checked <= responses_checked + 1;
            end
         end
         if (req_tvalid && req_tready) begin
            pending_rsp.push_back(predict_access(pcisb_pkg::op_type'(req_tuser),
                                                 req_tdata[2:0], req_tdata[10:3],
                                                 req_tdata[18:11]));
         end
      end
      outstanding <= pending_rsp.size();
   end

endmodule

/* tb/pci_southbridge_config_space_tb.sv */
// Top of the bridge configuration space testbench: clock, reset, access stimulus,
// response back-pressure, watchdog and verdict. Needs pcisb_pkg, the block
// pci_southbridge_config_space and the checker pcisb_access_checker.
`timescale 1ns / 1ps

module pci_southbridge_config_space_tb;

   localparam int RANDOM_ACCESSES = 600;
   localparam int PHASE_LEN       = 50;
   localparam int IDLE_LIMIT      = 2000;
   localparam int SETTLE_CYCLES   = 8;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_tvalid = 1'b0;
   logic                        req_tready;
   logic [1:0]                  req_tuser = pcisb_pkg::OP_CFG_READ;
   logic [pcisb_pkg::REQ_W-1:0] req_tdata = '0;
   logic                        rsp_tvalid;
   logic                        rsp_tready = 1'b0;
   logic [pcisb_pkg::RSP_W-1:0] rsp_tdata;

   int fail_count;
   int outstanding;
   int responses_checked;
   int accesses_sent = 0;
   int idle_cycles = 0;
   int rsp_hold = 0;
   bit req_no_gap = 1'b0;
   bit rsp_no_stall = 1'b0;

   always #1 clock = ~clock;

   pci_southbridge_config_space uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   pcisb_access_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_tvalid        (req_tvalid),
      .req_tready        (req_tready),
      .req_tuser         (req_tuser),
      .req_tdata         (req_tdata),
      .rsp_tvalid        (rsp_tvalid),
      .rsp_tready        (rsp_tready),
      .rsp_tdata         (rsp_tdata),
      .fail_count        (fail_count),
      .outstanding       (outstanding),
      .responses_checked (responses_checked)
   );

   // Response side: after each taken word, hold tready low for a drawn stall.
   always @(posedge clock) begin : rsp_sink
      int stall;
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_hold <= 0;
      end else if (rsp_tvalid && rsp_tready) begin
         stall = rsp_no_stall ? 0 : $urandom_range(0, 7);
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            rsp_hold <= stall - 1;
         end
      end else if (!rsp_tready) begin
         if (rsp_hold == 0) rsp_tready <= 1'b1;
         else rsp_hold <= rsp_hold - 1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("watchdog: no word moved for %0d cycles", IDLE_LIMIT);
         $display("pci_southbridge_config_space test failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Returns at the edge that accepts the word; tvalid stays high for a gapless next word.
   task automatic send_access(input pcisb_pkg::op_type op, input logic [2:0] fn,
                              input logic [7:0] addr, input logic [7:0] data);
      int gap;
      gap = req_no_gap ? 0 : $urandom_range(0, 7);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {5'd0, data, addr, fn};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      accesses_sent++;
   endtask

   // Hold off the sender until every predicted response has been taken.
   task automatic drain_responses();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   function automatic logic [7:0] pick_addr();
      case ($urandom_range(0, 3))
         0:       return 8'($urandom_range(0, 255));
         1:       return 8'($urandom_range(pcisb_pkg::REG_VENDOR_LO, pcisb_pkg::REG_RO_LO));
         2:       return $urandom_range(0, 1)
                     ? 8'($urandom_range(pcisb_pkg::REG_ROUTE_A, pcisb_pkg::REG_ROUTE_D))
                     : 8'($urandom_range(8'h4c, pcisb_pkg::REG_PORT92));
         default: return 8'($urandom_range(8'h40, 8'h63));
      endcase
   endfunction

   initial begin : stimulus
      logic [2:0] fn;
      logic [7:0] addr;
      logic [7:0] data;
      int         sel;
      int         phase_end;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: identity, other functions, masked and fixed bytes
      send_access(pcisb_pkg::OP_CFG_READ, 3'd0, 8'h00, 8'h00);
      send_access(pcisb_pkg::OP_CFG_READ, 3'd7, 8'hff, 8'hff);
      send_access(pcisb_pkg::OP_CFG_WRITE, 3'd3, 8'h80, 8'hff);
      send_access(pcisb_pkg::OP_CFG_READ, 3'd0, 8'h80, 8'h00);
      send_access(pcisb_pkg::OP_CFG_WRITE, 3'd0, pcisb_pkg::REG_COMMAND, 8'hff);
      send_access(pcisb_pkg::OP_CFG_READ, 3'd0, pcisb_pkg::REG_COMMAND, 8'h00);
      send_access(pcisb_pkg::OP_CFG_WRITE, 3'd0, pcisb_pkg::REG_STATUS_0, 8'hff);
      send_access(pcisb_pkg::OP_CFG_WRITE, 3'd0, pcisb_pkg::REG_STATUS_2, 8'h00);
      send_access(pcisb_pkg::OP_CFG_READ, 3'd0, pcisb_pkg::REG_STATUS_2, 8'h00);
      send_access(pcisb_pkg::OP_CFG_WRITE, 3'd0, 8'h20, 8'haa);
      send_access(pcisb_pkg::OP_CFG_WRITE, 3'd0, pcisb_pkg::REG_HDR_TYPE, 8'h55);
      send_access(pcisb_pkg::OP_CFG_WRITE, 3'd0, 8'h00, 8'hff);
      // port 92 gate: no toggle, clear, set
      send_access(pcisb_pkg::OP_CFG_WRITE, 3'd0, pcisb_pkg::REG_PORT92, 8'h4f);
      send_access(pcisb_pkg::OP_CFG_WRITE, 3'd0, pcisb_pkg::REG_PORT92, 8'h0f);
      send_access(pcisb_pkg::OP_CFG_WRITE, 3'd0, pcisb_pkg::REG_PORT92, 8'hff);
      // interrupt routing, one per pin, disabled and enabled
      send_access(pcisb_pkg::OP_CFG_WRITE, 3'd0, pcisb_pkg::REG_ROUTE_A, 8'h8a);
      send_access(pcisb_pkg::OP_CFG_WRITE, 3'd0, 8'h61, 8'h05);
      send_access(pcisb_pkg::OP_CFG_WRITE, 3'd0, 8'h62, 8'h0f);
      send_access(pcisb_pkg::OP_CFG_WRITE, 3'd0, pcisb_pkg::REG_ROUTE_D, 8'h80);
      send_access(pcisb_pkg::OP_CFG_WRITE, 3'd0, 8'hff, 8'hff);
      send_access(pcisb_pkg::OP_CFG_READ, 3'd0, 8'hff, 8'h00);
      // reset port: CPU reset, no request while the go bit stays set, then full reset restoring the table
      send_access(pcisb_pkg::OP_RST_WRITE, 3'd5, 8'h12, 8'h04);
      send_access(pcisb_pkg::OP_RST_WRITE, 3'd0, 8'h00, 8'hff);
      send_access(pcisb_pkg::OP_RST_READ, 3'd2, 8'h99, 8'h00);
      send_access(pcisb_pkg::OP_RST_WRITE, 3'd0, 8'h00, 8'h00);
      send_access(pcisb_pkg::OP_RST_WRITE, 3'd0, 8'h00, 8'h06);
      send_access(pcisb_pkg::OP_CFG_READ, 3'd0, 8'hff, 8'h00);
      send_access(pcisb_pkg::OP_RST_READ, 3'd0, 8'h00, 8'h00);
      drain_responses();

      // random phases: mostly function 0 write/read-back pairs on hot offsets
      phase_end = accesses_sent;
      while (accesses_sent < RANDOM_ACCESSES + 28) begin
         if (accesses_sent >= phase_end) begin
            drain_responses();
            phase_end = accesses_sent + PHASE_LEN;
            req_no_gap = ($urandom_range(0, 3) == 0);
            rsp_no_stall = ($urandom_range(0, 3) == 0);
         end
         sel = $urandom_range(0, 99);
         fn = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7)) : 3'd0;
         addr = pick_addr();
         data = 8'($urandom_range(0, 255));
         if (sel < 45) begin
            send_access(pcisb_pkg::OP_CFG_WRITE, fn, addr, data);
            send_access(pcisb_pkg::OP_CFG_READ, fn, addr, 8'($urandom_range(0, 255)));
         end else if (sel < 70) begin
            send_access(pcisb_pkg::OP_CFG_READ, fn, addr, data);
         end else if (sel < 90) begin
            send_access(pcisb_pkg::OP_CFG_WRITE, fn, addr, data);
         end else if (sel < 95) begin
            send_access(pcisb_pkg::OP_RST_READ, fn, addr, data);
         end else begin
            send_access(pcisb_pkg::OP_RST_WRITE, fn, addr, data);
         end
      end

      drain_responses();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("covered %0d accesses over all operations and functions, %0d responses checked",
               accesses_sent, responses_checked);
      $display("including reset requests, port 92 toggles and all four routing registers");
      if (fail_count == 0) begin
         $display("pci_southbridge_config_space test passed");
      end else begin
         $display("pci_southbridge_config_space test failed");
      end
      $finish;
   end

endmodule
